@@ rtl/cmhf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the class-map hole-fill filter: sizes, request and register
// codes, transfer payload structs and internal control structs. No dependencies.
package cmhf_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int LABEL_BITS  = 8;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int SUM_BITS    = LABEL_BITS + 3;

    localparam int DIM_BITS     = 7;
    localparam int PASS_BITS    = 4;
    localparam int IDX_BITS     = 12;
    localparam int VAL_BITS     = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 7;

    localparam logic [DIM_BITS-1:0]  RST_WIDTH  = DIM_BITS'(64);
    localparam logic [DIM_BITS-1:0]  RST_HEIGHT = DIM_BITS'(64);
    localparam logic [PASS_BITS-1:0] RST_PASSES = PASS_BITS'(5);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_PASSES = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_req                  req_type;
        logic [IDX_BITS-1:0]   cell_index;
        logic [VAL_BITS-1:0]   cell_value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_BITS-1:0]   read_value;
        logic                  run_done;
    } t_out_item;

    typedef struct packed {
        logic                  re;
        logic [ADDR_BITS:0]    raddr;
        logic                  we;
        logic [ADDR_BITS:0]    waddr;
        logic [LABEL_BITS-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic [PASS_BITS-1:0]  passes;
    } t_geom;

    typedef struct packed {
        logic                  done;
        logic                  bank;
    } t_eng_status;

endpackage

@@ rtl/class_map_hole_fill_filter_unit.sv @@
`timescale 1ns / 1ps
// Class-map hole-fill filter top level. Write and unknown items: result in the
// cycle after the transfer, one item per cycle unless the output stalls. Read
// items: result registered after the READ state, which stalls the input. Run items:
// per pass the sequencer visits all STORE_DEPTH cells, reading each cell and the
// eight neighbors of each zero interior cell (one label read per cycle, single read
// port). Synchronous active-low reset resets control and sets config to defaults;
// the label store is undefined until written. Depends on cmhf_pkg.
module class_map_hole_fill_filter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cmhf_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cmhf_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [cmhf_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [cmhf_pkg::CFG_BITS-1:0]     i_cfg_wdata
);
    import cmhf_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_READ = 3'b010,
        T_RUN  = 3'b100
    } t_top_state;

    t_top_state            r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    logic                  r_rd_ok, n_rd_ok;
    logic [DIM_BITS-1:0]   r_map_width;
    logic [DIM_BITS-1:0]   r_map_height;
    logic [PASS_BITS-1:0]  r_pass_count;

    logic                  in_acc;
    logic                  in_range;
    logic                  start;
    t_geom                 geom;
    t_mem_req              host_req;
    t_mem_req              eng_req;
    t_mem_req              mem_req;
    t_eng_status           eng_st;
    logic [LABEL_BITS-1:0] rdata;

    assign o_in_stall  = (r_state != T_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_range    = (32'(i_in_data.cell_index) < STORE_DEPTH);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign geom.width  = (32'(r_map_width) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : r_map_width;
    assign geom.height = (32'(r_map_height) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT) : r_map_height;
    assign geom.passes = r_pass_count;

    assign start = in_acc && (i_in_data.req_type == REQ_RUN);

    always_comb begin
        host_req.re    = in_acc && (i_in_data.req_type == REQ_READ);
        host_req.raddr = {eng_st.bank, ADDR_BITS'(i_in_data.cell_index)};
        host_req.we    = in_acc && (i_in_data.req_type == REQ_WRITE) && in_range;
        host_req.waddr = {eng_st.bank, ADDR_BITS'(i_in_data.cell_index)};
        host_req.wdata = LABEL_BITS'(i_in_data.cell_value);
    end

    assign mem_req = (r_state == T_RUN) ? eng_req : host_req;

    always_comb begin
        n_state     = r_state;
        n_rd_ok     = r_rd_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.req_type)
                        REQ_READ: begin
                            n_rd_ok = in_range;
                            n_state = T_READ;
                        end
                        REQ_RUN: n_state = T_RUN;
                        default: begin
                            n_out       = '0;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            T_READ: begin
                n_out.read_value = r_rd_ok ? VAL_BITS'(rdata) : '0;
                n_out.run_done   = 1'b0;
                n_out_valid      = 1'b1;
                n_state          = T_IDLE;
            end
            T_RUN: begin
                if (eng_st.done) begin
                    n_out.read_value = '0;
                    n_out.run_done   = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_out_valid  <= 1'b0;
            r_map_width  <= RST_WIDTH;
            r_map_height <= RST_HEIGHT;
            r_pass_count <= RST_PASSES;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH:  r_map_width  <= DIM_BITS'(i_cfg_wdata);
                    CFG_HEIGHT: r_map_height <= DIM_BITS'(i_cfg_wdata);
                    CFG_PASSES: r_pass_count <= PASS_BITS'(i_cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_rd_ok <= n_rd_ok;
    end

    cmhf_pass_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_geom   (geom),
        .i_rdata  (rdata),
        .o_mem    (eng_req),
        .o_status (eng_st)
    );

    cmhf_label_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

endmodule

@@ rtl/cmhf_label_ram.sv @@
`timescale 1ns / 1ps
// Label store: two banks of STORE_DEPTH labels in one array, one write and
// one registered read per cycle. Depends on cmhf_pkg.
module cmhf_label_ram (
    input  logic                           i_clk,
    input  cmhf_pkg::t_mem_req             i_req,
    output logic [cmhf_pkg::LABEL_BITS-1:0] o_rdata
);
    import cmhf_pkg::*;

    logic [LABEL_BITS-1:0] r_mem [2*STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

@@ rtl/cmhf_pass_engine.sv @@
`timescale 1ns / 1ps
// Fill-pass sequencer: sweeps the active bank, copies each cell to the other
// bank or refills a zero interior cell from eight neighbor reads through one
// shared adder, then swaps banks. Depends on cmhf_pkg.
module cmhf_pass_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  cmhf_pkg::t_geom                 i_geom,
    input  logic [cmhf_pkg::LABEL_BITS-1:0] i_rdata,
    output cmhf_pkg::t_mem_req              o_mem,
    output cmhf_pkg::t_eng_status           o_status
);
    import cmhf_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_CTR  = 4'b0010,
        E_CHK  = 4'b0100,
        E_NB   = 4'b1000
    } t_eng_state;

    t_eng_state            r_state;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [DIM_BITS-1:0]   r_col;
    logic [DIM_BITS-1:0]   r_row;
    logic                  r_in_map;
    logic [2:0]            r_k;
    logic [SUM_BITS-1:0]   r_acc;
    logic [PASS_BITS-1:0]  r_pass;
    logic                  r_bank;
    logic                  r_done;
    logic                  r_geom_ok;
    t_geom                 r_geom;

    logic                  interior;
    logic                  fill;
    logic                  adv;
    logic                  last_cell;
    logic [SUM_BITS-1:0]   sum;
    logic [2:0]            nb_k;
    logic [ADDR_BITS-1:0]  w_ext;
    logic [ADDR_BITS-1:0]  nb_row;
    logic [ADDR_BITS-1:0]  nb_addr;

    assign interior = r_geom_ok && r_in_map && (r_row != '0)
                   && (r_row != r_geom.height - DIM_BITS'(1))
                   && (r_col != '0) && (r_col != r_geom.width - DIM_BITS'(1));
    assign fill      = (r_state == E_CHK) && interior && (i_rdata == '0);
    assign adv       = ((r_state == E_CHK) && !fill) || ((r_state == E_NB) && (r_k == 3'd7));
    assign last_cell = (r_addr == ADDR_BITS'(STORE_DEPTH - 1));
    assign sum       = r_acc + SUM_BITS'(i_rdata);

    // neighbor order: up-left, up, up-right, left, right, down-left, down, down-right
    assign nb_k  = (r_state == E_CHK) ? 3'd0 : r_k + 3'd1;
    assign w_ext = ADDR_BITS'(r_geom.width);

    always_comb begin
        if (nb_k < 3'd3) begin
            nb_row = r_addr - w_ext;
        end else if (nb_k < 3'd5) begin
            nb_row = r_addr;
        end else begin
            nb_row = r_addr + w_ext;
        end
        case (nb_k)
            3'd0, 3'd3, 3'd5: nb_addr = nb_row - ADDR_BITS'(1);
            3'd2, 3'd4, 3'd7: nb_addr = nb_row + ADDR_BITS'(1);
            default:          nb_addr = nb_row;
        endcase
    end

    always_comb begin
        o_mem.re    = (r_state == E_CTR) || fill || ((r_state == E_NB) && (r_k != 3'd7));
        o_mem.raddr = (r_state == E_CTR) ? {r_bank, r_addr} : {r_bank, nb_addr};
        o_mem.we    = adv;
        o_mem.waddr = {~r_bank, r_addr};
        o_mem.wdata = (r_state == E_CHK) ? i_rdata : LABEL_BITS'(sum >> 3);
    end

    assign o_status.done = r_done;
    assign o_status.bank = r_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
            r_bank  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_geom    <= i_geom;
                        r_geom_ok <= (i_geom.width >= DIM_BITS'(3))
                                  && (i_geom.height >= DIM_BITS'(3));
                        r_addr    <= '0;
                        r_col     <= '0;
                        r_row     <= '0;
                        r_in_map  <= 1'b1;
                        r_pass    <= '0;
                        if (i_geom.passes == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= E_CTR;
                        end
                    end
                end
                E_CTR: begin
                    r_state <= E_CHK;
                end
                E_CHK: begin
                    if (fill) begin
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= E_NB;
                    end
                end
                E_NB: begin
                    r_acc <= sum;
                    r_k   <= r_k + 3'd1;
                end
                default: r_state <= E_IDLE;
            endcase

            if (adv) begin
                if (last_cell) begin
                    r_bank   <= ~r_bank;
                    r_addr   <= '0;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_in_map <= 1'b1;
                    if (r_pass == r_geom.passes - PASS_BITS'(1)) begin
                        r_state <= E_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_pass  <= r_pass + PASS_BITS'(1);
                        r_state <= E_CTR;
                    end
                end else begin
                    r_addr  <= r_addr + ADDR_BITS'(1);
                    r_state <= E_CTR;
                    if (r_col == r_geom.width - DIM_BITS'(1)) begin
                        r_col <= '0;
                        if (r_in_map) begin
                            if (r_row == r_geom.height - DIM_BITS'(1)) begin
                                r_in_map <= 1'b0;
                            end else begin
                                r_row <= r_row + DIM_BITS'(1);
                            end
                        end
                    end else begin
                        r_col <= r_col + DIM_BITS'(1);
                    end
                end
            end
        end
    end

endmodule

@@ rtl/cmhf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the class-map hole-fill filter, bound to the top
// level. Depends on cmhf_pkg and class_map_hole_fill_filter_unit.
module cmhf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  cmhf_pkg::t_in_item  i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  cmhf_pkg::t_out_item o_out_data
);
    import cmhf_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.req_type == REQ_RUN || i_in_data.req_type == REQ_READ)
        |=> o_in_stall)
        else $error("input not stalled during read or run");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.req_type == REQ_WRITE
        |=> o_out_valid && !o_out_data.run_done && o_out_data.read_value == '0)
        else $error("write transfer gave wrong result");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.req_type == REQ_READ |=> ##1 o_out_valid && !o_out_data.run_done)
        else $error("read result missing");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.run_done |-> o_out_data.read_value == '0)
        else $error("run result carries data");

endmodule

bind class_map_hole_fill_filter_unit cmhf_checker u_cmhf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
